### rtl/skvt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted key/value table package
// Shared types and codes for the sorted key/value table unit.
// ---------------------------------------------------------------------------
package skvt_pkg;

   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;

   // Request operation codes. The unused code is served as a lookup.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ABSENT  = 2'd1,
      STATUS_PRESENT = 2'd2,
      STATUS_FULL    = 2'd3
   } skvt_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_CHECK,
      ST_CHECK_CMP,
      ST_ACT,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_INS_WR,
      ST_FINISH
   } skvt_state_type;

endpackage

### rtl/sorted_key_value_table_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted key/value table unit
// Keeps key/value pairs sorted by signed key in one RAM, packed at the
// front. A small sequencer runs a binary search and then moves entries one
// per cycle to open or close a slot.
// ---------------------------------------------------------------------------
// Search: each binary search step is a RAM read and a compare.
// Throughput: one word at a time; the next request is taken once the current
// one has left the sequencer, even while its response still waits.
// Reset: synchronous; the table comes up empty, RAM contents are not cleared.
// ---------------------------------------------------------------------------
module sorted_key_value_table_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [skvt_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [skvt_pkg::KEY_W-1:0]      req_key,
   input  logic signed [skvt_pkg::VALUE_W-1:0]    req_value_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [skvt_pkg::STATUS_W-1:0]          rsp_status,
   output logic [skvt_pkg::POS_W-1:0]             rsp_position,
   output logic signed [skvt_pkg::VALUE_W-1:0]    rsp_value_out
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int DW = skvt_pkg::KEY_W + skvt_pkg::VALUE_W;

   skvt_pkg::skvt_state_type state_ff, state_in;
   logic [CW-1:0]  occ_ff, occ_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [skvt_pkg::KIND_W-1:0]         kind_ff, kind_in;
   logic signed [skvt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic signed [skvt_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [CW-1:0]  lo_ff, lo_in;
   logic [CW-1:0]  hi_ff, hi_in;
   logic [CW-1:0]  mid_ff, mid_in;
   logic [CW-1:0]  dst_ff, dst_in;
   logic           found_ff, found_in;
   logic signed [skvt_pkg::VALUE_W-1:0] hit_ff, hit_in;
   skvt_pkg::skvt_status_type status_ff, status_in;
   logic signed [skvt_pkg::VALUE_W-1:0] vout_ff, vout_in;

   skvt_pkg::skvt_status_type rsp_status_ff, rsp_status_in;
   logic [skvt_pkg::POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic signed [skvt_pkg::VALUE_W-1:0] rsp_vout_ff, rsp_vout_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [DW-1:0] rd_data;
   logic signed [skvt_pkg::KEY_W-1:0]   rd_key;
   logic signed [skvt_pkg::VALUE_W-1:0] rd_value;

   logic [CW-1:0] mid_calc;
   logic [CW:0]   pos_plus1;
   logic [CW:0]   dst_plus2;
   logic          rsp_load;

   assign rd_key   = rd_data[DW-1 -: skvt_pkg::KEY_W];
   assign rd_value = rd_data[skvt_pkg::VALUE_W-1:0];

   assign mid_calc  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign pos_plus1 = {1'b0, lo_ff} + (CW + 1)'(1);
   assign dst_plus2 = {1'b0, dst_ff} + (CW + 1)'(2);

   skvt_ram #(
      .WIDTH (DW),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skvt_pkg::ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      dst_ff        <= dst_in;
      found_ff      <= found_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      vout_ff       <= vout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_vout_ff   <= rsp_vout_in;
   end

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      dst_in        = dst_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      status_in     = status_ff;
      vout_in       = vout_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_vout_in   = rsp_vout_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_load      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;

      unique case (state_ff)
         skvt_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               key_in   = req_key;
               val_in   = req_value_in;
               lo_in    = '0;
               hi_in    = occ_ff;
               state_in = skvt_pkg::ST_SEARCH;
            end
         end
         skvt_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               rd_addr  = mid_calc[AW-1:0];
               state_in = skvt_pkg::ST_SEARCH_CMP;
            end else begin
               state_in = skvt_pkg::ST_CHECK;
            end
         end
         skvt_pkg::ST_SEARCH_CMP: begin
            if (rd_key < key_ff) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = skvt_pkg::ST_SEARCH;
         end
         skvt_pkg::ST_CHECK: begin
            // The search result is the first entry not below the key.
            found_in = 1'b0;
            hit_in   = '0;
            if (lo_ff < occ_ff) begin
               rd_addr  = lo_ff[AW-1:0];
               state_in = skvt_pkg::ST_CHECK_CMP;
            end else begin
               state_in = skvt_pkg::ST_ACT;
            end
         end
         skvt_pkg::ST_CHECK_CMP: begin
            found_in = (rd_key == key_ff);
            hit_in   = rd_value;
            state_in = skvt_pkg::ST_ACT;
         end
         skvt_pkg::ST_ACT: begin
            vout_in  = '0;
            state_in = skvt_pkg::ST_FINISH;
            case (kind_ff)
               skvt_pkg::KIND_INSERT: begin
                  if (found_ff) begin
                     status_in = skvt_pkg::STATUS_PRESENT;
                  end else if (occ_ff == CW'(TABLE_DEPTH)) begin
                     status_in = skvt_pkg::STATUS_FULL;
                  end else begin
                     status_in = skvt_pkg::STATUS_OK;
                     if (occ_ff > lo_ff) begin
                        rd_addr  = AW'(occ_ff - CW'(1));
                        dst_in   = occ_ff;
                        state_in = skvt_pkg::ST_SHIFT_UP;
                     end else begin
                        state_in = skvt_pkg::ST_INS_WR;
                     end
                  end
               end
               skvt_pkg::KIND_REMOVE: begin
                  if (found_ff) begin
                     status_in = skvt_pkg::STATUS_OK;
                     vout_in   = hit_ff;
                     if (pos_plus1 < {1'b0, occ_ff}) begin
                        rd_addr  = pos_plus1[AW-1:0];
                        dst_in   = lo_ff;
                        state_in = skvt_pkg::ST_SHIFT_DOWN;
                     end else begin
                        occ_in = occ_ff - CW'(1);
                     end
                  end else begin
                     status_in = skvt_pkg::STATUS_ABSENT;
                  end
               end
               default: begin
                  if (found_ff) begin
                     status_in = skvt_pkg::STATUS_OK;
                     vout_in   = hit_ff;
                  end else begin
                     status_in = skvt_pkg::STATUS_ABSENT;
                  end
               end
            endcase
         end
         skvt_pkg::ST_SHIFT_UP: begin
            // Write the entry read last cycle one slot higher, read the next.
            wr_en   = 1'b1;
            wr_addr = dst_ff[AW-1:0];
            wr_data = rd_data;
            dst_in  = dst_ff - CW'(1);
            if (dst_ff - CW'(1) > lo_ff) begin
               rd_addr = AW'(dst_ff - CW'(2));
            end else begin
               state_in = skvt_pkg::ST_INS_WR;
            end
         end
         skvt_pkg::ST_SHIFT_DOWN: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[AW-1:0];
            wr_data = rd_data;
            dst_in  = dst_ff + CW'(1);
            if (dst_plus2 < {1'b0, occ_ff}) begin
               rd_addr = dst_plus2[AW-1:0];
            end else begin
               occ_in   = occ_ff - CW'(1);
               state_in = skvt_pkg::ST_FINISH;
            end
         end
         skvt_pkg::ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_data  = {key_ff, val_ff};
            occ_in   = occ_ff + CW'(1);
            state_in = skvt_pkg::ST_FINISH;
         end
         skvt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pos_in    = skvt_pkg::POS_W'(lo_ff);
               rsp_vout_in   = vout_ff;
               state_in      = skvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skvt_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall     = (state_ff != skvt_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_value_out = rsp_vout_ff;

   // The occupancy never grows past the table depth.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(TABLE_DEPTH))
      else $error("occupancy exceeds table depth");

   // The search window stays ordered and inside the occupied entries.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skvt_pkg::ST_SEARCH || state_ff == skvt_pkg::ST_SEARCH_CMP)
      |-> (lo_ff <= hi_ff && hi_ff <= occ_ff))
      else $error("binary search window out of range");

   // A full status is only reported when the table really is full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && status_ff == skvt_pkg::STATUS_FULL |=> occ_ff == CW'(TABLE_DEPTH))
      else $error("full status with free entries");

   // A successful insert always leaves at least one occupied entry behind.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == skvt_pkg::ST_INS_WR |=> occ_ff != '0)
      else $error("insert left the table empty");

endmodule

### rtl/skvt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module skvt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
